>>> src/bit_window_hash_pattern_matcher_unit_assert.svh
// assertion macros for the checker file
`ifndef BIT_WINDOW_HASH_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define BIT_WINDOW_HASH_PATTERN_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BWHPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BWHPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bwhpm_pkg.sv
package bwhpm_pkg;

  // default sizes of the table and the pattern store
  localparam int TableBitsDef   = 12;
  localparam int HashPrimeDef   = 4093;
  localparam int MaxPatternsDef = 1023;
  localparam int MaxProbesDef   = 13;

  // fixed field widths
  localparam int CodeW   = 30;
  localparam int IndexW  = 10;
  localparam int LenW    = 5;
  localparam int StatusW = 3;
  localparam int ReqW    = 2;
  localparam int InDataW  = 48;
  localparam int OutDataW = 16;

  // window limits
  localparam logic [LenW-1:0] LenMax = 5'd30;
  localparam logic [LenW-1:0] LenMin = 5'd1;
  localparam logic [LenW-1:0] LenRst = 5'd8;

  // request kinds
  localparam logic [ReqW-1:0] REQ_INSERT  = 2'd0;
  localparam logic [ReqW-1:0] REQ_SHIFT   = 2'd1;
  localparam logic [ReqW-1:0] REQ_RESTART = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_INSERTED = 3'd0;
  localparam logic [StatusW-1:0] STATUS_FULL     = 3'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_FULL = 3'd2;
  localparam logic [StatusW-1:0] STATUS_MISS     = 3'd3;
  localparam logic [StatusW-1:0] STATUS_MATCH    = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_REDUCE,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_STORE_CHK,
    ST_RESP
  } state_e;

endpackage

>>> src/bit_window_hash_pattern_matcher_unit.sv
// Pattern matcher over a sliding bit window. Patterns are inserted into an
// open-addressed hash table held in a synchronous memory (home slot is the
// code modulo HASH_PRIME, probe steps 1, 2, 4, ... up to MAX_PROBES slots),
// with the codes kept in a second memory indexed by pattern number. After
// reset the block sweeps the slot table to empty, one slot a cycle, with
// s_axis_tready_o low; configuration writes are taken meanwhile. Shift
// requests that do not fill the window, restarts, unused request kinds and
// rejected inserts go from idle straight to the response state. For an
// insert or a lookup the home slot comes from a reciprocal multiplication
// followed by a multiply-back and one compare and subtract, in the MOD and
// REDUCE states, and each probe is one read of the slot memory followed, on
// a lookup of an occupied slot, by one read of the code memory. The result
// then waits in the response state until the output register is free.
module bit_window_hash_pattern_matcher_unit #(
  parameter int TABLE_BITS   = bwhpm_pkg::TableBitsDef,
  parameter int HASH_PRIME   = bwhpm_pkg::HashPrimeDef,
  parameter int MAX_PATTERNS = bwhpm_pkg::MaxPatternsDef,
  parameter int MAX_PROBES   = bwhpm_pkg::MaxProbesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: pattern_length
  input  logic                               cfg_we_i,
  input  logic [bwhpm_pkg::LenW-1:0]         cfg_wdata_i,
  // request stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [29:0] pattern_code, [39:30] pattern_index, [40] bit_in, rest zero
  input  logic [bwhpm_pkg::InDataW-1:0]      s_axis_tdata_i,
  // [1:0] req_type
  input  logic [bwhpm_pkg::ReqW-1:0]         s_axis_tuser_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [9:0] match_index, rest zero
  output logic [bwhpm_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // [2:0] status
  output logic [bwhpm_pkg::StatusW-1:0]      m_axis_tuser_o
);
  import bwhpm_pkg::*;

  localparam int SlotCount = 1 << TABLE_BITS;
  localparam int RemW      = $clog2(HASH_PRIME);
  localparam int StoreW    = $clog2(MAX_PATTERNS + 1);
  localparam int ProbeW    = $clog2(MAX_PROBES + 1);
  // reciprocal of the prime scaled by 2^CodeW, the quotient estimate is
  // at most one below the true quotient
  localparam int RecipM    = (1 << CodeW) / HASH_PRIME;
  localparam int RecipW    = $clog2(RecipM + 1);
  localparam int ProdW     = CodeW + RecipW;

  // memories
  logic [IndexW-1:0] slot_mem  [SlotCount];
  logic [CodeW-1:0]  store_mem [MAX_PATTERNS + 1];

  // control registers
  state_e              state_q, state_d;
  logic [TABLE_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic [LenW-1:0]     len_q;
  logic [CodeW-1:0]    win_q, win_d;
  logic [LenW-1:0]     fill_q, fill_d;
  logic                out_valid_q, out_valid_d;

  // payload registers
  logic                op_insert_q, op_insert_d;
  logic [CodeW-1:0]    code_q, code_d;
  logic [IndexW-1:0]   idx_q, idx_d;
  logic [RecipW-1:0]   quot_q, quot_d;
  logic [TABLE_BITS-1:0] pos_q, pos_d;
  logic [TABLE_BITS-1:0] step_q, step_d;
  logic [ProbeW-1:0]   probe_q, probe_d;
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic [IndexW-1:0]   res_match_q, res_match_d;
  logic [StatusW-1:0]  out_status_q, out_status_d;
  logic [IndexW-1:0]   out_match_q, out_match_d;
  logic [IndexW-1:0]   slot_rdata_q;
  logic [CodeW-1:0]    store_rdata_q;

  // memory controls
  logic                  slot_we, slot_re, store_we, store_re;
  logic [TABLE_BITS-1:0] slot_waddr;
  logic [IndexW-1:0]     slot_wdata;

  // request fields
  logic [ReqW-1:0]   req_type;
  logic [CodeW-1:0]  pattern_code;
  logic [IndexW-1:0] pattern_index;
  logic              bit_in;
  logic              in_fire;

  assign req_type      = s_axis_tuser_i;
  assign pattern_code  = s_axis_tdata_i[CodeW-1:0];
  assign pattern_index = s_axis_tdata_i[CodeW+IndexW-1:CodeW];
  assign bit_in        = s_axis_tdata_i[CodeW+IndexW];
  assign in_fire       = s_axis_tvalid_i && s_axis_tready_o;

  // decisions shared by the sequencer and the datapath
  logic [LenW-1:0]   eff_len;
  logic [CodeW-1:0]  len_mask;
  logic [CodeW-1:0]  win_shift;
  logic [LenW-1:0]   fill_inc;
  logic              shift_full;
  logic              idx_bad;
  logic [ProdW-1:0]  recip_prod;
  logic [CodeW-1:0]  rem_wide;
  logic [RemW-1:0]   rem_home;
  logic              slot_empty;
  logic              slot_known;
  logic              store_hit;
  logic              probe_last;
  logic              resp_free;
  logic              clr_done;

  always_comb begin
    if (len_q == '0) begin
      eff_len = LenMin;
    end else if (len_q > LenMax) begin
      eff_len = LenMax;
    end else begin
      eff_len = len_q;
    end
    len_mask   = (CodeW'(1) << eff_len) - CodeW'(1);
    win_shift  = {win_q[CodeW-2:0], bit_in};
    fill_inc   = (fill_q < LenMax) ? fill_q + LenW'(1) : fill_q;
    shift_full = fill_inc >= eff_len;
    idx_bad    = (pattern_index == '0) || (32'(pattern_index) > MAX_PATTERNS);
    // quotient estimate by reciprocal multiplication
    recip_prod = ProdW'(code_q) * ProdW'(RecipM);
    // remainder from the estimate, one correction at most
    rem_wide   = code_q - CodeW'(quot_q) * CodeW'(HASH_PRIME);
    if (rem_wide >= CodeW'(HASH_PRIME)) begin
      rem_wide = rem_wide - CodeW'(HASH_PRIME);
    end
    rem_home   = rem_wide[RemW-1:0];
    slot_empty = slot_rdata_q == '0;
    slot_known = 32'(slot_rdata_q) <= MAX_PATTERNS;
    store_hit  = store_rdata_q == code_q;
    probe_last = probe_q == ProbeW'(MAX_PROBES - 1);
    resp_free  = !out_valid_q || m_axis_tready_i;
    clr_done   = clr_cnt_q == TABLE_BITS'(SlotCount - 1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (req_type)
            REQ_INSERT: state_d = idx_bad ? ST_RESP : ST_MOD;
            REQ_SHIFT:  state_d = shift_full ? ST_MOD : ST_RESP;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_MOD: begin
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        state_d = ST_SLOT_RD;
      end
      ST_SLOT_RD: begin
        state_d = ST_SLOT_CHK;
      end
      ST_SLOT_CHK: begin
        if (slot_empty) begin
          state_d = ST_RESP;
        end else if (!op_insert_q && slot_known) begin
          state_d = ST_STORE_CHK;
        end else begin
          state_d = probe_last ? ST_RESP : ST_SLOT_RD;
        end
      end
      ST_STORE_CHK: begin
        state_d = (store_hit || probe_last) ? ST_RESP : ST_SLOT_RD;
      end
      ST_RESP: begin
        if (resp_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_cnt_d    = clr_cnt_q;
    win_d        = win_q;
    fill_d       = fill_q;
    op_insert_d  = op_insert_q;
    code_d       = code_q;
    idx_d        = idx_q;
    quot_d       = quot_q;
    pos_d        = pos_q;
    step_d       = step_q;
    probe_d      = probe_q;
    res_status_d = res_status_q;
    res_match_d  = res_match_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_match_d  = out_match_q;
    slot_we      = 1'b0;
    slot_re      = 1'b0;
    store_we     = 1'b0;
    store_re     = 1'b0;
    slot_waddr   = pos_q;
    slot_wdata   = idx_q;
    case (state_q)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt_q;
        slot_wdata = '0;
        clr_cnt_d  = clr_cnt_q + TABLE_BITS'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_status_d = STATUS_NOT_FULL;
          res_match_d  = '0;
          case (req_type)
            REQ_INSERT: begin
              op_insert_d = 1'b1;
              code_d      = pattern_code & len_mask;
              idx_d       = pattern_index;
              if (idx_bad) res_status_d = STATUS_FULL;
            end
            REQ_SHIFT: begin
              op_insert_d = 1'b0;
              win_d       = win_shift;
              fill_d      = fill_inc;
              code_d      = win_shift & len_mask;
            end
            REQ_RESTART: begin
              win_d  = '0;
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        quot_d = recip_prod[ProdW-1:CodeW];
      end
      ST_REDUCE: begin
        pos_d   = TABLE_BITS'(rem_home);
        step_d  = TABLE_BITS'(1);
        probe_d = '0;
      end
      ST_SLOT_RD: begin
        slot_re = 1'b1;
      end
      ST_SLOT_CHK: begin
        if (slot_empty) begin
          if (op_insert_q) begin
            slot_we      = 1'b1;
            store_we     = 1'b1;
            res_status_d = STATUS_INSERTED;
          end else begin
            res_status_d = STATUS_MISS;
          end
        end else if (!op_insert_q && slot_known) begin
          store_re = 1'b1;
        end else begin
          res_status_d = op_insert_q ? STATUS_FULL : STATUS_MISS;
          pos_d        = pos_q + step_q;
          step_d       = step_q << 1;
          probe_d      = probe_q + ProbeW'(1);
        end
      end
      ST_STORE_CHK: begin
        if (store_hit) begin
          res_status_d = STATUS_MATCH;
          res_match_d  = slot_rdata_q;
        end else begin
          res_status_d = STATUS_MISS;
          pos_d        = pos_q + step_q;
          step_d       = step_q << 1;
          probe_d      = probe_q + ProbeW'(1);
        end
      end
      ST_RESP: begin
        if (resp_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_match_d  = res_match_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      len_q       <= LenRst;
      win_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      win_q       <= win_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) len_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_insert_q  <= op_insert_d;
    code_q       <= code_d;
    idx_q        <= idx_d;
    quot_q       <= quot_d;
    pos_q        <= pos_d;
    step_q       <= step_d;
    probe_q      <= probe_d;
    res_status_q <= res_status_d;
    res_match_q  <= res_match_d;
    out_status_q <= out_status_d;
    out_match_q  <= out_match_d;
  end

  // slot table memory
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rdata_q <= slot_mem[pos_q];
  end

  // pattern code memory
  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[StoreW'(idx_q)] <= code_q;
    if (store_re) store_rdata_q <= store_mem[StoreW'(slot_rdata_q)];
  end

  // ports
  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_match_q);
  assign m_axis_tuser_o  = out_status_q;

endmodule

>>> src/bwhpm_checker.sv
module bwhpm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [bwhpm_pkg::LenW-1:0]     cfg_wdata_i,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [bwhpm_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic [bwhpm_pkg::ReqW-1:0]     s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [bwhpm_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [bwhpm_pkg::StatusW-1:0]  m_axis_tuser_o
);
  import bwhpm_pkg::*;

`include "bit_window_hash_pattern_matcher_unit_assert.svh"

  // a match always names a pattern
  `BWHPM_ASSERT_NOW(a_match_nonzero, m_axis_tvalid_o && (m_axis_tuser_o == STATUS_MATCH), m_axis_tdata_o != '0, "match reported with pattern number zero")

  // every other status carries no pattern number
  `BWHPM_ASSERT_NOW(a_other_zero, m_axis_tvalid_o && (m_axis_tuser_o != STATUS_MATCH), m_axis_tdata_o == '0, "pattern number on a result that is not a match")

  // status stays within the defined codes
  `BWHPM_ASSERT_NOW(a_status_range, m_axis_tvalid_o, m_axis_tuser_o <= STATUS_MATCH, "undefined status code")

  // a stalled result holds
  `BWHPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind bit_window_hash_pattern_matcher_unit bwhpm_checker u_bwhpm_checker (.*);

>>> dv/bit_window_hash_pattern_matcher_unit_tb.sv
module bit_window_hash_pattern_matcher_unit_tb;
  import bwhpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SlotCount = 1 << TableBitsDef;
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;
  localparam int StallLimit = 20000;
  localparam int TailCycles = 100;

  typedef struct packed {
    logic [ReqW-1:0]   kind;
    logic [CodeW-1:0]  code;
    logic [IndexW-1:0] idx;
    logic              bit_in;
  } match_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  match_index;
  } match_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [LenW-1:0] cfg_wdata = '0;
  logic req_tvalid = 1'b0;
  logic req_tready;
  logic [InDataW-1:0] req_tdata = '0;
  logic [ReqW-1:0] req_tuser = '0;
  logic res_tvalid;
  logic res_tready = 1'b0;
  logic [OutDataW-1:0] res_tdata;
  logic [StatusW-1:0] res_tuser;

  // requests waiting to be driven, results still owed by the block
  match_req_t pending_reqs[$];
  match_res_t owed_results[$];
  logic req_taken = 1'b0;
  int idle_pct = 26;
  int reqs_queued = 0;

  // shadow of the table, the code store, the window and the length register
  logic [IndexW-1:0] slot_tbl[SlotCount];
  logic [CodeW-1:0]  code_mem[MaxPatternsDef+1];
  logic [CodeW-1:0]  win_bits = '0;
  int                win_fill = 0;
  logic [LenW-1:0]   cur_len = LenRst;

  int errors = 0;
  int results_seen = 0;
  int reqs_seen = 0;
  int n_stored = 0;
  int n_rejected = 0;
  int n_hits = 0;
  int n_misses = 0;
  int stall_cycles = 0;

  bit_window_hash_pattern_matcher_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (req_tvalid),
    .s_axis_tready_o (req_tready),
    .s_axis_tdata_i  (req_tdata),
    .s_axis_tuser_i  (req_tuser),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tuser_o  (res_tuser)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < SlotCount; i++) slot_tbl[i] = '0;
    for (int i = 0; i <= MaxPatternsDef; i++) code_mem[i] = '0;
  end

  function automatic int eff_len();
    int n;
    n = int'(cur_len);
    if (n == 0) n = 1;
    if (n > 30) n = 30;
    return n;
  endfunction

  function automatic logic [CodeW-1:0] len_mask(int n);
    return (30'd1 << n) - 30'd1;
  endfunction

  function automatic int unsigned home_of(logic [CodeW-1:0] code);
    return (int'(code) % HashPrimeDef) & (SlotCount - 1);
  endfunction

  // place a pattern number on its probe chain
  function automatic logic [StatusW-1:0] table_insert(logic [CodeW-1:0] code,
                                                       logic [IndexW-1:0] idx);
    int unsigned pos;
    int unsigned step;
    pos = home_of(code);
    step = 1;
    if (idx == 0 || int'(idx) > MaxPatternsDef) return STATUS_FULL;
    for (int k = 0; k < MaxProbesDef; k++) begin
      if (slot_tbl[pos] == '0) begin
        slot_tbl[pos] = idx;
        code_mem[idx] = code;
        return STATUS_INSERTED;
      end
      pos = (pos + step) & (SlotCount - 1);
      step = step << 1;
    end
    return STATUS_FULL;
  endfunction

  // walk the probe chain for a window code, 0 when nothing matches
  function automatic logic [IndexW-1:0] table_lookup(logic [CodeW-1:0] code);
    int unsigned pos;
    int unsigned step;
    logic [IndexW-1:0] e;
    pos = home_of(code);
    step = 1;
    for (int k = 0; k < MaxProbesDef; k++) begin
      e = slot_tbl[pos];
      if (e == '0) return '0;
      if (int'(e) <= MaxPatternsDef && code_mem[e] == code) return e;
      pos = (pos + step) & (SlotCount - 1);
      step = step << 1;
    end
    return '0;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic match_res_t match_step(match_req_t r);
    match_res_t res;
    int n;
    n = eff_len();
    res.status = STATUS_NOT_FULL;
    res.match_index = '0;
    case (r.kind)
      REQ_INSERT: begin
        res.status = table_insert(r.code & len_mask(n), r.idx);
      end
      REQ_SHIFT: begin
        win_bits = {win_bits[CodeW-2:0], r.bit_in};
        if (win_fill < 30) win_fill++;
        if (win_fill >= n) begin
          res.match_index = table_lookup(win_bits & len_mask(n));
          res.status = (res.match_index != '0) ? STATUS_MATCH : STATUS_MISS;
        end
      end
      REQ_RESTART: begin
        win_bits = '0;
        win_fill = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // request driver and result ready, changes on the falling edge
  always @(negedge clk_i) begin
    match_req_t r;
    if (rst_ni) begin
      if (!req_tvalid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          r = pending_reqs.pop_front();
          req_tdata <= {{(InDataW - CodeW - IndexW - 1){1'b0}}, r.bit_in, r.idx, r.code};
          req_tuser <= r.kind;
          req_tvalid <= 1'b1;
        end else begin
          req_tvalid <= 1'b0;
        end
      end
      res_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // accepted requests feed the predictor, config writes update its length
  always @(posedge clk_i) begin
    match_req_t r;
    match_res_t exp_res;
    if (cfg_we) cur_len = cfg_wdata;
    if (req_tvalid && req_tready) begin
      r.kind = req_tuser;
      r.code = req_tdata[CodeW-1:0];
      r.idx = req_tdata[CodeW+IndexW-1:CodeW];
      r.bit_in = req_tdata[CodeW+IndexW];
      exp_res = match_step(r);
      owed_results.push_back(exp_res);
      reqs_seen++;
      case (exp_res.status)
        STATUS_INSERTED: n_stored++;
        STATUS_FULL:     n_rejected++;
        STATUS_MATCH:    n_hits++;
        STATUS_MISS:     n_misses++;
        default: ;
      endcase
    end
    req_taken <= req_tvalid && req_tready;
  end

  // result checker
  always @(posedge clk_i) begin
    match_res_t exp_res;
    if (res_tvalid && res_tready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d match_index %0d",
                   res_tuser, res_tdata[IndexW-1:0]);
      end else begin
        exp_res = owed_results.pop_front();
        if (res_tuser != exp_res.status || res_tdata[IndexW-1:0] != exp_res.match_index) begin
          errors++;
          if (errors <= 10)
            $display("result %0d mismatch: status exp %0d got %0d, match_index exp %0d got %0d",
                     results_seen, exp_res.status, res_tuser,
                     exp_res.match_index, res_tdata[IndexW-1:0]);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((req_tvalid && req_tready) || (res_tvalid && res_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", StallLimit);
      $display("bit_window_hash_pattern_matcher_unit_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_req(logic [ReqW-1:0] kind, logic [CodeW-1:0] code,
                          logic [IndexW-1:0] idx, logic bit_in);
    match_req_t r;
    r.kind = kind;
    r.code = code;
    r.idx = idx;
    r.bit_in = bit_in;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // shift one stream bit, other fields carry noise
  task automatic push_shift(logic b);
    push_req(REQ_SHIFT, CodeW'($urandom()), IndexW'($urandom()), b);
  endtask

  // stream a code into the window, most significant bit first
  task automatic push_code_bits(logic [CodeW-1:0] code, int n);
    for (int i = n - 1; i >= 0; i--) push_shift(code[i]);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || owed_results.size() != 0 || req_tvalid)
      @(negedge clk_i);
  endtask

  task automatic write_len(logic [LenW-1:0] v);
    wait_drained();
    repeat (8) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // random phase: inserts, restarts, unused kinds, noise and streams that mostly replay stored codes
  task automatic random_phase(int target);
    logic [CodeW-1:0] known[$];
    logic [CodeW-1:0] c;
    int stop;
    int roll;
    int n;
    n = eff_len();
    stop = reqs_queued + target;
    while (reqs_queued < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 16) begin
        c = CodeW'($urandom());
        known.push_back(c & len_mask(n));
        push_req(REQ_INSERT, c,
                 ($urandom_range(0, 99) < 4) ? IndexW'(0) : IndexW'($urandom_range(1, 1023)),
                 1'($urandom()));
      end else if (roll < 21) begin
        push_req(REQ_RESTART, CodeW'($urandom()), IndexW'($urandom()), 1'($urandom()));
      end else if (roll < 24) begin
        push_req(REQ_UNUSED, CodeW'($urandom()), IndexW'($urandom()), 1'($urandom()));
      end else if (known.size() != 0 && $urandom_range(0, 99) < 70) begin
        repeat ($urandom_range(0, 3)) push_shift(1'($urandom()));
        push_code_bits(known[$urandom_range(0, known.size() - 1)], n);
      end else begin
        repeat ($urandom_range(1, 8)) push_shift(1'($urandom()));
      end
    end
  endtask

  // stimulus
  initial begin
    logic [CodeW-1:0] chain_base;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, bad number, unused kind, duplicate number
    push_req(REQ_INSERT, 30'h3FFF_FFFF, 10'd1023, 1'b1);
    push_req(REQ_INSERT, 30'h0, 10'd1, 1'b0);
    push_req(REQ_INSERT, 30'h0, 10'd0, 1'b0);
    push_req(REQ_UNUSED, 30'h3FFF_FFFF, 10'h3FF, 1'b1);
    push_req(REQ_RESTART, 30'h0, 10'h0, 1'b0);
    repeat (8) push_shift(1'b1);
    push_req(REQ_INSERT, 30'h0A5, 10'd1, 1'b0);
    push_req(REQ_RESTART, 30'h3FFF_FFFF, 10'h3FF, 1'b1);
    repeat (8) push_shift(1'b0);
    random_phase(85);

    write_len(5'd1);
    random_phase(80);

    // full length: overload one probe chain that wraps past the table end
    write_len(5'd30);
    chain_base = 30'd4090 + 30'd4093 * 30'd1000;
    for (int k = 0; k < 14; k++)
      push_req(REQ_INSERT, chain_base + 30'(4093 * k), IndexW'(900 + k), 1'b0);
    push_req(REQ_RESTART, 30'h0, 10'h0, 1'b0);
    push_code_bits(chain_base + 30'(4093 * 20), 30);
    push_req(REQ_RESTART, 30'h0, 10'h0, 1'b0);
    push_code_bits(chain_base + 30'(4093 * 12), 30);
    random_phase(90);

    write_len(5'd0);
    random_phase(70);
    write_len(5'd31);
    random_phase(90);

    // back-to-back stretch with no idling on either side
    write_len(5'd4);
    wait_drained();
    idle_pct = 0;
    random_phase(90);
    wait_drained();
    idle_pct = 26;

    write_len(5'd12);
    random_phase(90);
    write_len(5'd5);
    random_phase(80);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (owed_results.size() != 0) begin
      errors++;
      $display("%0d results never arrived", owed_results.size());
    end
    $display("%0d requests over eight length settings, %0d results checked",
             reqs_seen, results_seen);
    $display("stored %0d, rejected %0d, window hits %0d, window misses %0d",
             n_stored, n_rejected, n_hits, n_misses);
    if (errors == 0) begin
      $display("bit_window_hash_pattern_matcher_unit_tb: done, clean");
    end else begin
      $display("bit_window_hash_pattern_matcher_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/bwhpm_pkg.sv
src/bit_window_hash_pattern_matcher_unit.sv
src/bwhpm_checker.sv
dv/bit_window_hash_pattern_matcher_unit_tb.sv
